>>> rtl/sjwc_pkg.sv
// ----------------------------------------------------------------------------
// sjwc_pkg
// Shared constants and types for the staircase jump way counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sjwc_pkg;

	localparam int MAX_STEPS_DEF = 128;
	localparam int FIELD_W       = 8;
	localparam int COUNT_W       = 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_READ,
		ST_CALC
	} state_t;

endpackage : sjwc_pkg

`default_nettype wire

>>> rtl/staircase_jump_way_counter_top.sv
// ----------------------------------------------------------------------------
// staircase_jump_way_counter_top
// Counts the ways to climb N steps with jumps of 1 to K steps.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A bad request
// (K = 0, K > N or N > MAX_STEPS) gives its result in the cycle after it is
// taken, so the next request can be taken once that result cycle ends. A
// valid request seeds the table, then alternates table write-and-read and
// update states until the index reaches N, and then gives its result; the
// next request can be taken once that result cycle ends. The result appears
// on way_count, overflowed and bad_request for exactly one cycle with done
// high and cannot be held off; busy stays high until that cycle ends.
// ----------------------------------------------------------------------------
`default_nettype none

module staircase_jump_way_counter_top #(
	parameter int MAX_STEPS = sjwc_pkg::MAX_STEPS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [sjwc_pkg::FIELD_W-1:0]   stair_count,
	input  wire logic [sjwc_pkg::FIELD_W-1:0]   max_jump,
	output logic                                done,
	output logic      [sjwc_pkg::COUNT_W-1:0]   way_count,
	output logic                                overflowed,
	output logic                                bad_request
);

	localparam int DEPTH = MAX_STEPS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (AW > sjwc_pkg::FIELD_W) ? AW + 1 : sjwc_pkg::FIELD_W + 1;
	localparam int DW    = sjwc_pkg::COUNT_W;

	sjwc_pkg::state_t state_q, state_d;

	logic [AW-1:0] n_q, k_q, idx_q;
	logic [DW-1:0] cur_q;
	logic          ovf_q;
	logic          done_q;

	logic          req_bad;
	logic          req_take;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [DW-1:0] wr_data, rd_data;
	logic [DW-1:0] term;
	logic [DW:0]   next_sum;

	assign req_bad = (max_jump == '0) || (max_jump > stair_count)
		|| (CW'(stair_count) > CW'(MAX_STEPS));

	assign req_take = start && !busy;

	sjwc_table #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sjwc_pkg::ST_IDLE: begin
				if (req_take && !req_bad) begin
					state_d = sjwc_pkg::ST_INIT;
				end
			end
			sjwc_pkg::ST_INIT: state_d = sjwc_pkg::ST_READ;
			sjwc_pkg::ST_READ: begin
				if (idx_q == n_q) begin
					state_d = sjwc_pkg::ST_IDLE;
				end else begin
					state_d = sjwc_pkg::ST_CALC;
				end
			end
			sjwc_pkg::ST_CALC: state_d = sjwc_pkg::ST_READ;
			default:           state_d = sjwc_pkg::ST_IDLE;
		endcase
	end

	// outputs to the table
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = cur_q;
		rd_en   = 1'b0;
		rd_addr = idx_q - k_q;
		unique case (state_q)
			sjwc_pkg::ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = DW'(1);
			end
			sjwc_pkg::ST_READ: begin
				wr_en = (idx_q != n_q);
				rd_en = (idx_q != n_q);
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	// ways(i+1) = 2*ways(i) - ways(i-K), the last term only once i >= K
	assign term     = (idx_q >= k_q) ? rd_data : '0;
	assign next_sum = {cur_q, 1'b0} - {1'b0, term};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sjwc_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (req_take && req_bad)
				|| ((state_q == sjwc_pkg::ST_READ) && (idx_q == n_q));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sjwc_pkg::ST_IDLE: begin
				n_q <= AW'(stair_count);
				k_q <= AW'(max_jump);
				if (req_take && req_bad) begin
					way_count   <= '0;
					overflowed  <= 1'b0;
					bad_request <= 1'b1;
				end
			end
			sjwc_pkg::ST_INIT: begin
				idx_q <= AW'(1);
				cur_q <= DW'(1);
				ovf_q <= 1'b0;
			end
			sjwc_pkg::ST_READ: begin
				if (idx_q == n_q) begin
					way_count   <= ovf_q ? '1 : cur_q;
					overflowed  <= ovf_q;
					bad_request <= 1'b0;
				end
			end
			sjwc_pkg::ST_CALC: begin
				cur_q <= next_sum[DW-1:0];
				ovf_q <= ovf_q | next_sum[DW];
				idx_q <= idx_q + AW'(1);
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign busy = (state_q != sjwc_pkg::ST_IDLE) || done_q;
	assign done = done_q;

endmodule : staircase_jump_way_counter_top

`default_nettype wire

>>> rtl/sjwc_table.sv
// ----------------------------------------------------------------------------
// sjwc_table
// Single-port-write, single-port-read synchronous table of way counts with
// a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sjwc_table #(
	parameter int DEPTH = sjwc_pkg::MAX_STEPS_DEF + 1,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = sjwc_pkg::COUNT_W
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : sjwc_table

`default_nettype wire

>>> tb/tb_staircase_jump_way_counter_top.sv
// ----------------------------------------------------------------------------
// tb_staircase_jump_way_counter_top
// Self-checking bench for the staircase jump way counter.
// ----------------------------------------------------------------------------
// Sends staircase requests (steps N, largest jump K) through the start/busy
// handshake. A short list of hand-picked requests comes first: bad requests,
// single-step jumps, window clamping and the 64-bit overflow edges. Random
// requests follow, mostly well formed with some bad ones and raw noise. Each
// request taken is given its expected count, either typed in or worked out
// by a saturating k-bonacci predictor. Every done strobe is checked against
// the oldest expected count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_staircase_jump_way_counter_top;

	localparam int MAX_STEPS = sjwc_pkg::MAX_STEPS_DEF;
	localparam int CW        = sjwc_pkg::COUNT_W;
	localparam int FW        = sjwc_pkg::FIELD_W;
	localparam int NUM_RAND  = 1375;
	localparam int CALM_TAIL = 200;
	localparam logic [CW-1:0] ALL_ONES = '1;

	typedef struct {
		logic [CW-1:0] count;
		logic          ovf;
		logic          bad;
	} way_res_t;

	typedef struct {
		logic [FW-1:0] n;
		logic [FW-1:0] k;
		bit            typed;
		logic [CW-1:0] count;
		logic          ovf;
		logic          bad;
	} stair_req_t;

	localparam int NUM_DIR = 22;

	stair_req_t directed_reqs [NUM_DIR] = '{
		'{8'd0,   8'd0,   1'b1, 64'd0, 1'b0, 1'b1},
		'{8'd0,   8'd1,   1'b1, 64'd0, 1'b0, 1'b1},
		'{8'd5,   8'd0,   1'b1, 64'd0, 1'b0, 1'b1},
		'{8'd3,   8'd4,   1'b1, 64'd0, 1'b0, 1'b1},
		'{8'd129, 8'd1,   1'b1, 64'd0, 1'b0, 1'b1},
		'{8'd200, 8'd3,   1'b1, 64'd0, 1'b0, 1'b1},
		'{8'd255, 8'd255, 1'b1, 64'd0, 1'b0, 1'b1},
		'{8'd1,   8'd1,   1'b1, 64'd1, 1'b0, 1'b0},
		'{8'd2,   8'd1,   1'b1, 64'd1, 1'b0, 1'b0},
		'{8'd128, 8'd1,   1'b1, 64'd1, 1'b0, 1'b0},
		'{8'd2,   8'd2,   1'b1, 64'd2, 1'b0, 1'b0},
		'{8'd3,   8'd2,   1'b1, 64'd3, 1'b0, 1'b0},
		'{8'd3,   8'd3,   1'b1, 64'd4, 1'b0, 1'b0},
		'{8'd10,  8'd2,   1'b1, 64'd89, 1'b0, 1'b0},
		'{8'd64,  8'd64,  1'b1, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
		'{8'd65,  8'd65,  1'b1, ALL_ONES, 1'b1, 1'b0},
		'{8'd93,  8'd2,   1'b1, ALL_ONES, 1'b1, 1'b0},
		'{8'd128, 8'd128, 1'b1, ALL_ONES, 1'b1, 1'b0},
		'{8'd92,  8'd2,   1'b0, 64'd0, 1'b0, 1'b0},
		'{8'd6,   8'd3,   1'b0, 64'd0, 1'b0, 1'b0},
		'{8'd128, 8'd127, 1'b0, 64'd0, 1'b0, 1'b0},
		'{8'd40,  8'd7,   1'b0, 64'd0, 1'b0, 1'b0}
	};

	logic          clk         = 1'b0;
	logic          arst_n      = 1'b0;
	logic          start       = 1'b0;
	logic [FW-1:0] stair_count = '0;
	logic [FW-1:0] max_jump    = '0;
	logic          busy;
	logic          done;
	logic [CW-1:0] way_count;
	logic          overflowed;
	logic          bad_request;

	way_res_t expected_ways [$];
	int       mismatches = 0;

	staircase_jump_way_counter_top #(
		.MAX_STEPS (MAX_STEPS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.stair_count (stair_count),
		.max_jump    (max_jump),
		.done        (done),
		.way_count   (way_count),
		.overflowed  (overflowed),
		.bad_request (bad_request)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic way_res_t count_ways(input logic [FW-1:0] n, input logic [FW-1:0] k);
		logic [CW-1:0] ways [0:MAX_STEPS];
		logic          over [0:MAX_STEPS];
		logic [CW:0]   total;
		logic [CW-1:0] acc;
		logic          ovf;
		int            lo;
		way_res_t      res;
		if (k < 1 || k > n || n > MAX_STEPS) begin
			res = '{count: '0, ovf: 1'b0, bad: 1'b1};
			return res;
		end
		ways[0] = CW'(1);
		over[0] = 1'b0;
		ways[1] = CW'(1);
		over[1] = 1'b0;
		for (int i = 2; i <= n; i++) begin
			lo  = (i > k) ? i - k : 0;
			acc = '0;
			ovf = 1'b0;
			for (int j = lo; j < i; j++) begin
				if (over[j])
					ovf = 1'b1;
				total = {1'b0, acc} + {1'b0, ways[j]};
				if (total[CW]) begin
					ovf = 1'b1;
					acc = ALL_ONES;
				end else begin
					acc = total[CW-1:0];
				end
			end
			ways[i] = ovf ? ALL_ONES : acc;
			over[i] = ovf;
		end
		res.count = over[n] ? ALL_ONES : ways[n];
		res.ovf   = over[n];
		res.bad   = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		$display("[%0t] %s: got %0h, expected %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		way_res_t want;
		if (done) begin
			if (expected_ways.size() == 0) begin
				report_mismatch("unexpected done", way_count, '0);
			end else begin
				want = expected_ways.pop_front();
				if (way_count !== want.count)
					report_mismatch("way_count", way_count, want.count);
				if (overflowed !== want.ovf)
					report_mismatch("overflowed", CW'(overflowed), CW'(want.ovf));
				if (bad_request !== want.bad)
					report_mismatch("bad_request", CW'(bad_request), CW'(want.bad));
			end
		end
	end

	// hold the request until taken, then maybe drop start for a burst
	task automatic send_request(input stair_req_t req, input bit may_idle);
		way_res_t want;
		start       <= 1'b1;
		stair_count <= req.n;
		max_jump    <= req.k;
		do @(posedge clk); while (busy);
		if (req.typed)
			want = '{count: req.count, ovf: req.ovf, bad: req.bad};
		else
			want = count_ways(req.n, req.k);
		expected_ways.push_back(want);
		if (may_idle && $urandom_range(0, 2) == 0) begin
			start       <= 1'b0;
			stair_count <= FW'($urandom);
			max_jump    <= FW'($urandom);
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic stair_req_t random_request();
		stair_req_t req;
		int         sel;
		int         n;
		req = '{n: '0, k: '0, typed: 1'b0, count: '0, ovf: 1'b0, bad: 1'b0};
		sel = $urandom_range(0, 19);
		if (sel < 14) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_STEPS)
			                                : $urandom_range(1, 40);
			req.n = FW'(n);
			case ($urandom_range(0, 3))
				0: req.k = FW'(1);
				1: req.k = FW'(n);
				2: req.k = FW'($urandom_range(1, (n < 4) ? n : 4));
				default: req.k = FW'($urandom_range(1, n));
			endcase
		end else if (sel < 16) begin
			req.n = FW'($urandom_range(0, 254));
			req.k = FW'($urandom_range(req.n + 1, 255));
		end else if (sel < 17) begin
			req.n = FW'($urandom_range(MAX_STEPS + 1, 255));
			req.k = FW'($urandom_range(0, 255));
		end else if (sel < 18) begin
			req.n = FW'($urandom_range(0, 255));
			req.k = '0;
		end else begin
			req.n = FW'($urandom);
			req.k = FW'($urandom);
		end
		return req;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_reqs[i])
			send_request(directed_reqs[i], 1'b1);
		for (int r = 0; r < NUM_RAND; r++)
			send_request(random_request(), r < NUM_RAND - CALM_TAIL);
		start <= 1'b0;
		while (expected_ways.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule : tb_staircase_jump_way_counter_top

`default_nettype wire
